>>> rtl/chip8_instruction_core_defines.svh
// ----------------------------------------------------------------------------
// CHIP-8 instruction core: assertion macros
// Concurrent checks on clk, disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef CHIP8_INSTRUCTION_CORE_DEFINES_SVH
`define CHIP8_INSTRUCTION_CORE_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define C8_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("c8ic check failed");
`define C8_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("c8ic check failed");
`else
`define C8_ASSERT(lbl, prop)
`define C8_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

>>> rtl/c8ic_pkg.sv
// ----------------------------------------------------------------------------
// c8ic_pkg
// Word types, operation and status codes, font table and BCD helper.
// ----------------------------------------------------------------------------
package c8ic_pkg;

  typedef struct packed {
    logic [2:0]  operation;
    logic [11:0] address;
    logic [7:0]  data;
    logic [7:0]  random_value;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [7:0]  key_asked;
    logic [11:0] program_counter;
    logic        sound_on;
    logic [63:0] row_pixels;
  } out_item_t;

  // register file request
  typedef struct packed {
    logic       clear;
    logic       we;
    logic [3:0] waddr;
    logic [7:0] wdata;
    logic [3:0] raddr;
  } vreq_t;

  localparam logic [2:0] OP_WRITE   = 3'd0;
  localparam logic [2:0] OP_STEP    = 3'd1;
  localparam logic [2:0] OP_WAITKEY = 3'd2;
  localparam logic [2:0] OP_KEYANS  = 3'd3;
  localparam logic [2:0] OP_DRAWACK = 3'd4;
  localparam logic [2:0] OP_READROW = 3'd5;
  localparam logic [2:0] OP_SOFTRST = 3'd6;

  localparam logic [2:0] MODE_RUN     = 3'd0;
  localparam logic [2:0] MODE_DRAW    = 3'd1;
  localparam logic [2:0] MODE_WAITKEY = 3'd2;
  localparam logic [2:0] MODE_KEYQ    = 3'd3;
  localparam logic [2:0] MODE_DONE    = 3'd4;
  localparam logic [2:0] MODE_FAULT   = 3'd5;
  localparam logic [2:0] ST_DENIED    = 3'd6;

  localparam logic [11:0] NNN_EXIT = 12'h0FD;
  localparam logic [11:0] NNN_RET  = 12'h0EE;
  localparam logic [11:0] NNN_CLS  = 12'h0E0;
  localparam logic [7:0]  NN_SKP   = 8'h9E;
  localparam logic [7:0]  NN_SKNP  = 8'hA1;
  localparam logic [7:0]  NN_GETDT = 8'h07;
  localparam logic [7:0]  NN_WAITK = 8'h0A;
  localparam logic [7:0]  NN_SETDT = 8'h15;
  localparam logic [7:0]  NN_SETST = 8'h18;
  localparam logic [7:0]  NN_ADDI  = 8'h1E;
  localparam logic [7:0]  NN_FONT  = 8'h29;
  localparam logic [7:0]  NN_BCD   = 8'h33;
  localparam logic [7:0]  NN_STORE = 8'h55;
  localparam logic [7:0]  NN_LOAD  = 8'h65;

  localparam int FONT_BYTES = 80;

  localparam logic [7:0] FONT [FONT_BYTES] = '{
    8'hF0,8'h90,8'h90,8'h90,8'hF0, 8'h20,8'h60,8'h20,8'h20,8'h70,
    8'hF0,8'h10,8'hF0,8'h80,8'hF0, 8'hF0,8'h10,8'hF0,8'h10,8'hF0,
    8'h90,8'h90,8'hF0,8'h10,8'h10, 8'hF0,8'h80,8'hF0,8'h10,8'hF0,
    8'hF0,8'h80,8'hF0,8'h90,8'hF0, 8'hF0,8'h10,8'h20,8'h40,8'h40,
    8'hF0,8'h90,8'hF0,8'h90,8'hF0, 8'hF0,8'h90,8'hF0,8'h10,8'hF0,
    8'hF0,8'h90,8'hF0,8'h90,8'h90, 8'hE0,8'h90,8'hE0,8'h90,8'hE0,
    8'hF0,8'h80,8'h80,8'h80,8'hF0, 8'hE0,8'h90,8'h90,8'h90,8'hE0,
    8'hF0,8'h80,8'hF0,8'h80,8'hF0, 8'hF0,8'h80,8'hF0,8'h80,8'h80
  };

  // {hundreds, tens, ones}; reciprocal multiplies, exact for 0..255
  function automatic logic [11:0] bcd3(input logic [7:0] r);
    logic [13:0] ph;
    logic [1:0]  h;
    logic [6:0]  rem;
    logic [14:0] pt;
    logic [3:0]  t;
    logic [3:0]  o;
    ph  = 14'(r) * 14'd41;
    h   = ph[13:12];
    rem = 7'(r - 8'(8'(h) * 8'd100));
    pt  = 15'(rem) * 15'd205;
    t   = pt[14:11];
    o   = 4'(rem - 7'(7'(t) * 7'd10));
    return {2'b00, h, t, o};
  endfunction

endpackage

>>> rtl/c8ic_vfile.sv
// ----------------------------------------------------------------------------
// c8ic_vfile
// V0..VF register file: 16x8 synchronous RAM, one write and one registered
// read per cycle, per-entry valid bits so that a clear resets only the valid bits, not the RAM.
// ----------------------------------------------------------------------------
module c8ic_vfile (
  input  logic             clk,
  input  logic             rst_n,
  input  c8ic_pkg::vreq_t  req,
  output logic [7:0]       rdata
);
  import c8ic_pkg::*;

  logic [7:0]  ram [16];
  logic [7:0]  q_r;
  logic [15:0] vld_r;
  logic        ok_r;

  always_ff @(posedge clk) begin
    if (req.we) begin
      ram[req.waddr] <= req.wdata;
    end
    q_r <= ram[req.raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
      ok_r  <= 1'b0;
    end else begin
      ok_r <= vld_r[req.raddr];
      if (req.clear) begin
        vld_r <= '0;
      end else if (req.we) begin
        vld_r[req.waddr] <= 1'b1;
      end
    end
  end

  // entries not written since reset or the last clear read as zero
  assign rdata = ok_r ? q_r : 8'd0;

endmodule

>>> rtl/chip8_instruction_core.sv
// ----------------------------------------------------------------------------
// chip8_instruction_core
// CHIP-8 interpreter core: 4 KiB memory, 64x32 display, sequenced execution.
// ----------------------------------------------------------------------------
// Use: one input word (in_valid/in_ready) yields exactly one result word
// (out_valid/out_ready). Input words are write byte, step, waited key, key
// answer, draw ack, read row and soft reset; results carry status, queried
// key, pc, sound flag and the requested display row.
// One word is worked on at a time; in_ready is high only when the sequencer
// is idle. Every access goes through the main memory, display RAM, stack
// RAM and register-file RAM, each with one write and one registered read
// per cycle.
// After reset a clearing pass over all 4096 bytes loads the font and zeroes the
// rest of memory; in_ready stays low meanwhile.
// If the receiver stalls, the finished word holds in the output register; the
// next word is still taken and worked, and waits in S_EMIT until it is free.
// ----------------------------------------------------------------------------
`include "chip8_instruction_core_defines.svh"

module chip8_instruction_core #(
  parameter int STACK_DEPTH   = 16,
  parameter int PROGRAM_START = 512
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  c8ic_pkg::in_item_t    in_item,
  output logic                  out_valid,
  input  logic                  out_ready,
  output c8ic_pkg::out_item_t   out_item
);
  import c8ic_pkg::*;

  localparam int SW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int CW = $clog2(STACK_DEPTH + 1);
  localparam logic [11:0] PC_START = 12'(PROGRAM_START);

  typedef enum logic [23:0] {
    S_CLR   = 24'h000001, S_IDLE  = 24'h000002, S_DISP  = 24'h000004,
    S_RROW  = 24'h000008, S_F0    = 24'h000010, S_F1    = 24'h000020,
    S_F2    = 24'h000040, S_F3    = 24'h000080, S_F4    = 24'h000100,
    S_EXEC  = 24'h000200, S_RET   = 24'h000400, S_WRF   = 24'h000800,
    S_D_RD  = 24'h001000, S_D_WR  = 24'h002000, S_D_END = 24'h004000,
    S_B0    = 24'h008000, S_B1    = 24'h010000, S_B2    = 24'h020000,
    S_C55R  = 24'h040000, S_C55W  = 24'h080000, S_M65R  = 24'h100000,
    S_M65W  = 24'h200000, S_FIN   = 24'h400000, S_EMIT  = 24'h800000
  } state_t;

  state_t st_r;

  // architectural state
  logic [11:0] pc_r;
  logic [15:0] ireg_r;
  logic [CW-1:0] sc_r;
  logic [7:0]  dly_r, snd_r;
  logic [2:0]  mode_r;
  logic [7:0]  pend_r;
  logic        skipnp_r;
  logic [31:0] dvalid_r;

  // work registers
  in_item_t    item_r;
  logic [7:0]  hi_r, lo_r, vx_r, vy_r;
  logic [11:0] npc_r;
  logic [2:0]  nmode_r;
  logic        tick_r, deny_r, flag_r, coll_r, dok_r;
  logic [3:0]  i_r;
  logic [5:0]  x0_r;
  logic [4:0]  yy_r;
  logic [11:0] bcd_r;
  logic [11:0] clr_r;
  logic [63:0] row_r;
  out_item_t   out_r;
  logic        out_valid_r;

  // memories
  logic [7:0]  mem [4096];
  logic        mem_we;
  logic [11:0] mem_waddr, mem_raddr;
  logic [7:0]  mem_wdata, mem_q;
  logic [63:0] disp [32];
  logic        disp_we;
  logic [4:0]  disp_waddr, disp_raddr;
  logic [63:0] disp_wdata, disp_q;
  logic [11:0] stk [STACK_DEPTH];
  logic        stk_we;
  logic [SW-1:0] stk_waddr, stk_raddr;
  logic [11:0] stk_q;

  vreq_t       vreq;
  logic [7:0]  v_q;

  c8ic_vfile u_vfile (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (vreq),
    .rdata (v_q)
  );

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    mem_q <= mem[mem_raddr];
  end

  always_ff @(posedge clk) begin
    if (disp_we) begin
      disp[disp_waddr] <= disp_wdata;
    end
    disp_q <= disp[disp_raddr];
  end

  always_ff @(posedge clk) begin
    if (stk_we) begin
      stk[stk_waddr] <= pc_r;
    end
    stk_q <= stk[stk_raddr];
  end

  // instruction fields
  logic [3:0]  nib, vx_i, vy_i, nlo;
  logic [11:0] nnn;
  logic [11:0] ibase;
  logic [CW-1:0] sc_m1;
  logic [7:0]  alu_res;
  logic        alu_ok, alu_fl, alu_has_fl;
  logic [8:0]  sum9;
  logic [127:0] spr_dbl;
  logic [63:0] spr_m, drow;

  assign nib   = hi_r[7:4];
  assign vx_i  = hi_r[3:0];
  assign vy_i  = lo_r[7:4];
  assign nlo   = lo_r[3:0];
  assign nnn   = {hi_r[3:0], lo_r};
  assign ibase = ireg_r[11:0];
  assign sc_m1 = sc_r - 1'b1;
  assign sum9  = {1'b0, vx_r} + {1'b0, vy_r};

  always_comb begin
    alu_res    = vy_r;
    alu_ok     = 1'b1;
    alu_fl     = 1'b0;
    alu_has_fl = 1'b0;
    case (nlo)
      4'h0: alu_res = vy_r;
      4'h1: alu_res = vx_r | vy_r;
      4'h2: alu_res = vx_r & vy_r;
      4'h3: alu_res = vx_r ^ vy_r;
      4'h4: begin
        alu_res = sum9[7:0]; alu_fl = sum9[8]; alu_has_fl = 1'b1;
      end
      4'h5: begin
        alu_res = vx_r - vy_r; alu_fl = (vx_r >= vy_r); alu_has_fl = 1'b1;
      end
      4'h6: begin
        alu_res = {1'b0, vx_r[7:1]}; alu_fl = vx_r[0]; alu_has_fl = 1'b1;
      end
      4'h7: begin
        alu_res = vy_r - vx_r; alu_fl = (vy_r >= vx_r); alu_has_fl = 1'b1;
      end
      4'hE: begin
        alu_res = {vx_r[6:0], 1'b0}; alu_fl = vx_r[7]; alu_has_fl = 1'b1;
      end
      default: alu_ok = 1'b0;
    endcase
  end

  // sprite byte placed at x0, wrapping at the right edge
  assign spr_dbl = {mem_q, 56'd0, mem_q, 56'd0} >> x0_r;
  assign spr_m   = spr_dbl[63:0];
  assign drow    = dok_r ? disp_q : 64'd0;

  // memory port control
  always_comb begin
    mem_we     = 1'b0;
    mem_waddr  = clr_r;
    mem_wdata  = 8'd0;
    mem_raddr  = pc_r;
    disp_we    = 1'b0;
    disp_waddr = yy_r;
    disp_wdata = drow ^ spr_m;
    disp_raddr = yy_r;
    stk_we     = 1'b0;
    stk_waddr  = sc_r[SW-1:0];
    stk_raddr  = sc_m1[SW-1:0];
    vreq       = '0;
    vreq.waddr = vx_i;
    vreq.raddr = vx_i;
    case (st_r)
      S_CLR: begin
        mem_we = 1'b1;
        if (clr_r < 12'(FONT_BYTES)) begin
          mem_wdata = FONT[clr_r[6:0]];
        end
      end
      S_DISP: begin
        disp_raddr = item_r.address[4:0];
        if (item_r.operation == OP_WRITE) begin
          mem_we    = 1'b1;
          mem_waddr = item_r.address;
          mem_wdata = item_r.data;
        end
        if (item_r.operation == OP_WAITKEY && mode_r == MODE_WAITKEY) begin
          vreq.we    = 1'b1;
          vreq.waddr = pend_r[3:0];
          vreq.wdata = item_r.data;
        end
        vreq.clear = (item_r.operation == OP_SOFTRST);
      end
      S_F1:   mem_raddr = pc_r + 12'd1;
      S_F3:   vreq.raddr = (nib == 4'hB) ? 4'd0 : vy_i;
      S_EXEC: begin
        case (nib)
          4'h2: stk_we = (sc_r < CW'(STACK_DEPTH));
          4'h6: begin vreq.we = 1'b1; vreq.wdata = lo_r; end
          4'h7: begin vreq.we = 1'b1; vreq.wdata = vx_r + lo_r; end
          4'h8: begin vreq.we = alu_ok; vreq.wdata = alu_res; end
          4'hC: begin vreq.we = 1'b1; vreq.wdata = item_r.random_value & lo_r; end
          4'hF: begin vreq.we = (lo_r == NN_GETDT); vreq.wdata = dly_r; end
          default: ;
        endcase
      end
      S_WRF: begin
        vreq.we = 1'b1; vreq.waddr = 4'hF; vreq.wdata = {7'd0, flag_r};
      end
      S_D_RD: mem_raddr = ibase + {8'd0, i_r};
      S_D_WR: disp_we = 1'b1;
      S_D_END: begin
        vreq.we = 1'b1; vreq.waddr = 4'hF; vreq.wdata = {7'd0, coll_r};
      end
      S_B0: begin
        mem_we = 1'b1; mem_waddr = ibase + 12'd2; mem_wdata = {4'd0, bcd_r[3:0]};
      end
      S_B1: begin
        mem_we = 1'b1; mem_waddr = ibase + 12'd1; mem_wdata = {4'd0, bcd_r[7:4]};
      end
      S_B2: begin
        mem_we = 1'b1; mem_waddr = ibase; mem_wdata = {4'd0, bcd_r[11:8]};
      end
      S_C55R: vreq.raddr = i_r;
      S_C55W: begin
        mem_we = 1'b1; mem_waddr = ibase + {8'd0, i_r}; mem_wdata = v_q;
      end
      S_M65R: mem_raddr = ibase + {8'd0, i_r};
      S_M65W: begin
        vreq.we = 1'b1; vreq.waddr = i_r; vreq.wdata = mem_q;
      end
      default: ;
    endcase
  end

  assign in_ready  = (st_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_item  = out_r;

  // fault: pc and timers untouched
  task automatic do_fault();
    nmode_r <= MODE_FAULT;
    npc_r   <= pc_r;
    tick_r  <= 1'b0;
    st_r    <= S_FIN;
  endtask

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= S_CLR;
      clr_r       <= '0;
      pc_r        <= PC_START;
      ireg_r      <= '0;
      sc_r        <= '0;
      dly_r       <= '0;
      snd_r       <= '0;
      mode_r      <= MODE_RUN;
      pend_r      <= '0;
      skipnp_r    <= 1'b0;
      dvalid_r    <= '0;
      out_valid_r <= 1'b0;
      dok_r       <= 1'b0;
    end else begin
      dok_r <= dvalid_r[disp_raddr];
      if (disp_we) begin
        dvalid_r[disp_waddr] <= 1'b1;
      end
      if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
      case (st_r)
        S_CLR: begin
          clr_r <= clr_r + 12'd1;
          if (clr_r == 12'hFFF) begin
            st_r <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_valid) begin
            item_r <= in_item;
            st_r   <= S_DISP;
          end
        end
        S_DISP: begin
          deny_r <= 1'b0;
          row_r  <= '0;
          st_r   <= S_EMIT;
          case (item_r.operation)
            OP_WRITE: ;
            OP_STEP: begin
              if (mode_r != MODE_RUN) begin
                deny_r <= 1'b1;
              end else begin
                st_r <= S_F0;
              end
            end
            OP_WAITKEY: begin
              if (mode_r != MODE_WAITKEY) begin
                deny_r <= 1'b1;
              end else begin
                pc_r   <= pc_r + 12'd2;
                mode_r <= MODE_RUN;
              end
            end
            OP_KEYANS: begin
              if (mode_r != MODE_KEYQ) begin
                deny_r <= 1'b1;
              end else begin
                pc_r   <= (((item_r.data != 8'd0) != skipnp_r)) ? pc_r + 12'd4
                                                                  : pc_r + 12'd2;
                mode_r <= MODE_RUN;
              end
            end
            OP_DRAWACK: begin
              if (mode_r != MODE_DRAW) begin
                deny_r <= 1'b1;
              end else begin
                pc_r   <= pc_r + 12'd2;
                mode_r <= MODE_RUN;
              end
            end
            OP_READROW: st_r <= S_RROW;
            OP_SOFTRST: begin
              dvalid_r <= '0;
              ireg_r   <= '0;
              sc_r     <= '0;
              pc_r     <= PC_START;
              mode_r   <= MODE_RUN;
              pend_r   <= '0;
              skipnp_r <= 1'b0;
            end
            default: deny_r <= 1'b1;
          endcase
        end
        S_RROW: begin
          row_r <= (item_r.address[11:5] == 7'd0) ? drow : 64'd0;
          st_r  <= S_EMIT;
        end
        S_F0: st_r <= S_F1;
        S_F1: begin
          hi_r <= mem_q;
          st_r <= S_F2;
        end
        S_F2: begin
          lo_r <= mem_q;
          st_r <= S_F3;
        end
        S_F3: begin
          vx_r <= v_q;
          st_r <= S_F4;
        end
        S_F4: begin
          vy_r <= v_q;
          st_r <= S_EXEC;
        end
        S_EXEC: begin
          npc_r   <= pc_r + 12'd2;
          nmode_r <= MODE_RUN;
          tick_r  <= 1'b1;
          i_r     <= '0;
          st_r    <= S_FIN;
          case (nib)
            4'h0: begin
              if (nnn == NNN_EXIT) begin
                nmode_r <= MODE_DONE;
                npc_r   <= pc_r;
              end else if (nnn == NNN_RET) begin
                if (sc_r == '0) begin
                  do_fault();
                end else begin
                  sc_r <= sc_m1;
                  st_r <= S_RET;
                end
              end else if (nnn == NNN_CLS) begin
                dvalid_r <= '0;
              end else begin
                do_fault();
              end
            end
            4'h1: npc_r <= nnn;
            4'h2: begin
              if (sc_r >= CW'(STACK_DEPTH)) begin
                do_fault();
              end else begin
                sc_r  <= sc_r + 1'b1;
                npc_r <= nnn;
              end
            end
            4'h3: if (vx_r == lo_r) npc_r <= pc_r + 12'd4;
            4'h4: if (vx_r != lo_r) npc_r <= pc_r + 12'd4;
            4'h5: if (vx_r == vy_r) npc_r <= pc_r + 12'd4;
            4'h8: begin
              if (!alu_ok) begin
                do_fault();
              end else if (alu_has_fl) begin
                flag_r <= alu_fl;
                st_r   <= S_WRF;
              end
            end
            4'h9: begin
              if (nlo != 4'd0) begin
                do_fault();
              end else if (vx_r != vy_r) begin
                npc_r <= pc_r + 12'd4;
              end
            end
            4'hA: ireg_r <= {4'd0, nnn};
            4'hB: npc_r <= nnn + {4'd0, vy_r};
            4'hD: begin
              nmode_r <= MODE_DRAW;
              npc_r   <= pc_r;
              x0_r    <= vx_r[5:0];
              yy_r    <= vy_r[4:0];
              coll_r  <= 1'b0;
              st_r    <= (nlo == 4'd0) ? S_D_END : S_D_RD;
            end
            4'hE: begin
              if (lo_r != NN_SKP && lo_r != NN_SKNP) begin
                do_fault();
              end else begin
                pend_r   <= vx_r;
                skipnp_r <= (lo_r == NN_SKNP);
                nmode_r  <= MODE_KEYQ;
                npc_r    <= pc_r;
              end
            end
            4'hF: begin
              case (lo_r)
                NN_GETDT: ;
                NN_WAITK: begin
                  pend_r  <= {4'd0, vx_i};
                  nmode_r <= MODE_WAITKEY;
                  npc_r   <= pc_r;
                end
                NN_SETDT: dly_r <= vx_r;
                NN_SETST: snd_r <= vx_r;
                NN_ADDI:  ireg_r <= ireg_r + {8'd0, vx_r};
                NN_FONT:  ireg_r <= 16'({4'd0, vx_r[3:0]} * 8'd5);
                NN_BCD: begin
                  bcd_r <= bcd3(vx_r);
                  st_r  <= S_B0;
                end
                NN_STORE: st_r <= S_C55R;
                NN_LOAD:  st_r <= S_M65R;
                default:  do_fault();
              endcase
            end
            default: ;
          endcase
        end
        S_RET: begin
          npc_r <= stk_q + 12'd2;
          st_r  <= S_FIN;
        end
        S_WRF:  st_r <= S_FIN;
        S_D_RD: st_r <= S_D_WR;
        S_D_WR: begin
          coll_r <= coll_r | (|(drow & spr_m));
          yy_r   <= yy_r + 5'd1;
          i_r    <= i_r + 4'd1;
          st_r   <= (i_r + 4'd1 == nlo) ? S_D_END : S_D_RD;
        end
        S_D_END: st_r <= S_FIN;
        S_B0:    st_r <= S_B1;
        S_B1:    st_r <= S_B2;
        S_B2:    st_r <= S_FIN;
        S_C55R:  st_r <= S_C55W;
        S_C55W: begin
          i_r  <= i_r + 4'd1;
          st_r <= (i_r == vx_i) ? S_FIN : S_C55R;
        end
        S_M65R: st_r <= S_M65W;
        S_M65W: begin
          i_r  <= i_r + 4'd1;
          st_r <= (i_r == vx_i) ? S_FIN : S_M65R;
        end
        S_FIN: begin
          pc_r   <= npc_r;
          mode_r <= nmode_r;
          if (tick_r) begin
            if (dly_r != 8'd0) dly_r <= dly_r - 8'd1;
            if (snd_r != 8'd0) snd_r <= snd_r - 8'd1;
          end
          st_r <= S_EMIT;
        end
        S_EMIT: begin
          if (!out_valid_r || out_ready) begin
            out_r.status          <= deny_r ? ST_DENIED : mode_r;
            out_r.key_asked       <= (mode_r == MODE_KEYQ) ? pend_r : 8'd0;
            out_r.program_counter <= pc_r;
            out_r.sound_on        <= (snd_r != 8'd0);
            out_r.row_pixels      <= row_r;
            out_valid_r           <= 1'b1;
            st_r                  <= S_IDLE;
          end
        end
        default: st_r <= S_IDLE;
      endcase
    end
  end

  `C8_ASSERT(a_stack_bound, sc_r <= CW'(STACK_DEPTH))
  `C8_ASSERT_NEXT(a_accept_dispatch, in_valid && in_ready, st_r == S_DISP)
  `C8_ASSERT(a_fault_holds, (st_r == S_FIN && nmode_r == MODE_FAULT) |-> npc_r == pc_r && !tick_r)
  `C8_ASSERT(a_draw_rows, (st_r == S_D_WR) |-> (i_r < nlo))

endmodule
